[src/ilst_pkg.sv]
// Shared types for the indexed list store: command and result transactions,
// command codes and the control word broadcast to the cell row.
// No dependencies.
package ilst_pkg;

    typedef enum logic [3:0] {
        MODE_INSERT       = 4'd0,
        MODE_APPEND       = 4'd1,
        MODE_REMOVE_INDEX = 4'd2,
        MODE_REMOVE_VALUE = 4'd3,
        MODE_GET          = 4'd4,
        MODE_FIND         = 4'd5,
        MODE_COUNT        = 4'd6,
        MODE_CLEAR        = 4'd7,
        MODE_REVERSE      = 4'd8,
        MODE_SORT         = 4'd9
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [6:0]         index;
        logic signed [31:0] value;
    } t_ilst_in;

    typedef struct packed {
        logic               status;
        logic signed [31:0] data;
        logic               found;
        logic [5:0]         position;
        logic [6:0]         tally;
        logic [6:0]         length;
        logic               is_empty;
    } t_ilst_out;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_STEP
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     order;  // step builds an ordered tail region
        logic     keyed;  // ordered region is placed by value (sort), else reversed
    } t_cell_ctl;

endpackage

[src/ilst_cell.sv]
// One storage cell of the list row: holds one word and trades it with its
// neighbors for insert, remove, rotate and ordering steps.
// Depends on ilst_pkg.
module ilst_cell
    import ilst_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int CAPACITY  = 64,
    parameter int POS       = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_cell_ctl                            i_ctl,
    input  logic [$clog2(CAPACITY + 1) - 1:0]    i_at,
    input  logic [$clog2(CAPACITY + 1) - 1:0]    i_fill,
    input  logic [WORD_BITS-1:0]                 i_value,
    input  logic [WORD_BITS-1:0]                 i_head,
    input  logic [WORD_BITS-1:0]                 i_left_word,
    input  logic [WORD_BITS-1:0]                 i_right_word,
    input  logic                                 i_right_give,
    input  logic                                 i_right_live,
    input  logic                                 i_right_sorted,
    output logic [WORD_BITS-1:0]                 o_word,
    output logic                                 o_give,
    output logic                                 o_live,
    output logic                                 o_sorted
);

    localparam int FW = $clog2(CAPACITY + 1);
    localparam logic [FW-1:0] MY_POS = FW'(POS);

    logic [WORD_BITS-1:0] r_word, n_word;
    logic                 r_sorted, n_sorted;
    logic                 w_le;

    assign o_word   = r_word;
    assign o_sorted = r_sorted;
    assign o_live   = (MY_POS < i_fill);

    // An ordered entry at or below the head value moves up to make room.
    assign w_le   = r_sorted && i_ctl.keyed && ($signed(r_word) <= $signed(i_head));
    assign o_give = o_live && (!r_sorted || w_le);

    always_comb begin
        n_word   = r_word;
        n_sorted = 1'b0;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (MY_POS > i_at) begin
                    n_word = i_left_word;
                end else if (MY_POS == i_at) begin
                    n_word = i_value;
                end
            end
            CELL_REMOVE: begin
                if (MY_POS >= i_at) begin
                    n_word = i_right_word;
                end
            end
            CELL_STEP: begin
                // Take the neighbor's word when it moves up, else drop the head in
                // where this word just left.
                if (i_right_give) begin
                    n_word = i_right_word;
                end else if (o_give) begin
                    n_word = i_head;
                end
                n_sorted = i_ctl.order && o_live &&
                           (r_sorted || !i_right_live || i_right_sorted);
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sorted <= 1'b0;
        end else begin
            r_sorted <= n_sorted;
        end
    end

endmodule

[src/indexed_list_store.sv]
// Top level of the indexed list store: command sequencer, fill count,
// result register and the row of ilst_cell storage cells.
// Depends on ilst_pkg and ilst_cell.
//
// The list lives in a row of CAPACITY cells, cell 0 holding the first entry.
// Insert, append and remove at index shift the row and clear resets the fill
// count without a scan, so these commands (and any command that fails or has
// nothing to do, such as get past the end or a scan of an empty list) finish
// on the command transaction itself: the result goes to the output
// register when it is free, and the next command is taken in the same
// cycle that result is offered. Get, find and count rotate the stored
// entries once past cell 0; remove by value then adds a drop step to
// remove the entry found. Reverse and sort pop the entry in cell 0 each
// cycle and place it into an ordered region that grows at the tail of the
// row (a stable insertion sort by signed value, or a reversal). These walks
// rotate the cell row one position a cycle. Cell contents are not cleared
// at reset; only the fill count is. A finished result waits in the output
// register while the next command is being worked on; a command that
// finishes while the previous result is still waiting holds there until
// the output side takes it.
module indexed_list_store
    import ilst_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_ilst_in  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_ilst_out o_out
);

    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = (FW > 7) ? FW : 7;
    localparam logic [FW-1:0] FULL = FW'(CAPACITY);
    localparam logic [FW-1:0] ONE  = FW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DROP,
        S_ORDER,
        S_SEND
    } t_state;

    t_state               r_state, n_state;
    logic [FW-1:0]        r_fill, n_fill;
    logic [FW-1:0]        r_step, n_step;
    logic [FW-1:0]        r_cnt, n_cnt;
    logic [FW-1:0]        r_pos, n_pos;
    logic                 r_found, n_found;
    logic [WORD_BITS-1:0] r_data, n_data;
    logic [WORD_BITS-1:0] r_key, n_key;
    logic [6:0]           r_idx, n_idx;
    t_mode                r_mode, n_mode;
    t_ilst_out            r_res;
    t_ilst_out            r_out;
    logic                 r_out_valid;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_done;
    t_ilst_out            w_res;
    t_cell_ctl            w_ctl;
    logic [FW-1:0]        w_at;
    logic [WORD_BITS-1:0] w_in_word;
    logic [WORD_BITS-1:0] w_head;
    logic                 w_match;
    logic                 w_last;
    logic                 w_empty;
    logic [CW-1:0]        w_idx_ext;
    logic [CW-1:0]        w_fill_ext;

    logic [WORD_BITS-1:0] w_word   [CAPACITY];
    logic                 w_give   [CAPACITY];
    logic                 w_live   [CAPACITY];
    logic                 w_sorted [CAPACITY];

    // Pack one result transaction; narrow counts to the result field widths.
    function automatic t_ilst_out make_res(
        input logic                 status,
        input logic [WORD_BITS-1:0] data,
        input logic                 found,
        input logic [FW-1:0]        pos,
        input logic [FW-1:0]        cnt,
        input logic [FW-1:0]        fill
    );
        t_ilst_out res;
        res.status   = status;
        res.data     = 32'($signed(data));
        res.found    = found;
        res.position = 6'(pos);
        res.tally    = 7'(cnt);
        res.length   = 7'(fill);
        res.is_empty = (fill == '0);
        return res;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Narrow or sign-extend the command value to the stored word width.
    assign w_in_word  = WORD_BITS'(i_in.value);
    assign w_head     = w_word[0];
    assign w_match    = (w_head == r_key);
    assign w_last     = (r_step == r_fill - ONE);
    assign w_empty    = (r_fill == '0);
    assign w_idx_ext  = CW'(i_in.index);
    assign w_fill_ext = CW'(r_fill);

    // Cell row: each cell sees its two neighbors; the row ends are tied off.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [WORD_BITS-1:0] w_left_word;
        logic [WORD_BITS-1:0] w_right_word;
        logic                 w_right_give;
        logic                 w_right_live;
        logic                 w_right_sorted;

        if (k == 0) begin : g_first
            assign w_left_word = w_word[k];
        end else begin : g_inner_left
            assign w_left_word = w_word[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign w_right_word   = w_word[k];
            assign w_right_give   = 1'b0;
            assign w_right_live   = 1'b0;
            assign w_right_sorted = 1'b0;
        end else begin : g_inner_right
            assign w_right_word   = w_word[k+1];
            assign w_right_give   = w_give[k+1];
            assign w_right_live   = w_live[k+1];
            assign w_right_sorted = w_sorted[k+1];
        end

        ilst_cell #(
            .WORD_BITS (WORD_BITS),
            .CAPACITY  (CAPACITY),
            .POS       (k)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_at           (w_at),
            .i_fill         (r_fill),
            .i_value        (n_key),
            .i_head         (w_head),
            .i_left_word    (w_left_word),
            .i_right_word   (w_right_word),
            .i_right_give   (w_right_give),
            .i_right_live   (w_right_live),
            .i_right_sorted (w_right_sorted),
            .o_word         (w_word[k]),
            .o_give         (w_give[k]),
            .o_live         (w_live[k]),
            .o_sorted       (w_sorted[k])
        );
    end

    // The row takes the insert value from the key register's next value, so
    // an insert writes the incoming word as the command is accepted.
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_step   = r_step;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_found  = r_found;
        n_data   = r_data;
        n_key    = r_key;
        n_idx    = r_idx;
        n_mode   = r_mode;
        w_ctl    = '{op: CELL_HOLD, order: 1'b0, keyed: 1'b0};
        w_at     = '0;
        w_done   = 1'b0;
        w_res    = make_res(1'b1, '0, 1'b0, '0, '0, r_fill);

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mode  = i_in.mode;
                    n_key   = w_in_word;
                    n_idx   = i_in.index;
                    n_step  = '0;
                    n_cnt   = '0;
                    n_pos   = '0;
                    n_found = 1'b0;
                    n_data  = '0;
                    case (i_in.mode)
                        MODE_INSERT: begin
                            w_done = 1'b1;
                            if (r_fill != FULL && w_idx_ext <= w_fill_ext) begin
                                w_ctl.op = CELL_INSERT;
                                w_at     = FW'(i_in.index);
                                n_fill   = r_fill + ONE;
                                w_res    = make_res(1'b0, '0, 1'b0, '0, '0, n_fill);
                            end
                        end
                        MODE_APPEND: begin
                            w_done = 1'b1;
                            if (r_fill != FULL) begin
                                w_ctl.op = CELL_INSERT;
                                w_at     = r_fill;
                                n_fill   = r_fill + ONE;
                                w_res    = make_res(1'b0, '0, 1'b0, '0, '0, n_fill);
                            end
                        end
                        MODE_REMOVE_INDEX: begin
                            w_done = 1'b1;
                            if (w_idx_ext < w_fill_ext) begin
                                w_ctl.op = CELL_REMOVE;
                                w_at     = FW'(i_in.index);
                                n_fill   = r_fill - ONE;
                                w_res    = make_res(1'b0, '0, 1'b0, '0, '0, n_fill);
                            end
                        end
                        MODE_GET: begin
                            if (w_idx_ext < w_fill_ext) begin
                                n_state = S_SCAN;
                            end else begin
                                w_done = 1'b1;
                            end
                        end
                        MODE_REMOVE_VALUE, MODE_FIND: begin
                            if (w_empty) begin
                                w_done = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        MODE_COUNT: begin
                            if (w_empty) begin
                                w_done = 1'b1;
                                w_res  = make_res(1'b0, '0, 1'b0, '0, '0, r_fill);
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        MODE_CLEAR: begin
                            w_done = 1'b1;
                            n_fill = '0;
                            w_res  = make_res(1'b0, '0, 1'b0, '0, '0, '0);
                        end
                        MODE_REVERSE, MODE_SORT: begin
                            if (r_fill > ONE) begin
                                n_state = S_ORDER;
                            end else begin
                                w_done = 1'b1;
                                w_res  = make_res(1'b0, '0, 1'b0, '0, '0, r_fill);
                            end
                        end
                        default: begin
                            w_done = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Rotate the list one place; the entry at cell 0 is entry r_step.
                w_ctl   = '{op: CELL_STEP, order: 1'b0, keyed: 1'b0};
                n_step  = r_step + ONE;
                n_cnt   = r_cnt + FW'(w_match);
                n_found = r_found || w_match;
                n_pos   = (!r_found && w_match) ? r_step : r_pos;
                n_data  = (r_step == FW'(r_idx)) ? w_head : r_data;
                if (w_last) begin
                    case (r_mode)
                        MODE_GET: begin
                            w_done = 1'b1;
                            w_res  = make_res(1'b0, n_data, 1'b0, '0, '0, r_fill);
                        end
                        MODE_FIND: begin
                            w_done = 1'b1;
                            w_res  = make_res(!n_found, '0, n_found, n_pos, '0, r_fill);
                        end
                        MODE_COUNT: begin
                            w_done = 1'b1;
                            w_res  = make_res(1'b0, '0, 1'b0, '0, n_cnt, r_fill);
                        end
                        MODE_REMOVE_VALUE: begin
                            if (n_found) begin
                                n_state = S_DROP;
                            end else begin
                                w_done = 1'b1;
                            end
                        end
                        default: begin
                            w_done = 1'b1;
                        end
                    endcase
                end
            end
            S_DROP: begin
                w_ctl.op = CELL_REMOVE;
                w_at     = r_pos;
                n_fill   = r_fill - ONE;
                w_done   = 1'b1;
                w_res    = make_res(1'b0, '0, 1'b0, '0, '0, n_fill);
            end
            S_ORDER: begin
                // Pop cell 0 into the ordered tail; sort places it by value.
                w_ctl  = '{op: CELL_STEP, order: 1'b1, keyed: (r_mode == MODE_SORT)};
                n_step = r_step + ONE;
                if (w_last) begin
                    w_done = 1'b1;
                    w_res  = make_res(1'b0, '0, 1'b0, '0, '0, r_fill);
                end
            end
            S_SEND: begin
                n_state = r_state;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, counters and the output register. A finished result goes
    // straight to the output register when it is free; otherwise hold it in
    // r_res until the output side takes the pending transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
            r_found <= n_found;
            r_data  <= n_data;
            r_key   <= n_key;
            r_idx   <= n_idx;
            r_mode  <= n_mode;
            if (w_done && w_out_free) begin
                r_out       <= w_res;
                r_out_valid <= 1'b1;
                r_state     <= S_IDLE;
            end else if (w_done) begin
                r_res   <= w_res;
                r_state <= S_SEND;
            end else if (r_state == S_SEND && w_out_free) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
                r_state     <= S_IDLE;
            end else begin
                r_state <= n_state;
                if (r_out_valid && i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL)
        else $error("fill count exceeds capacity");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_fill == $past(r_fill) || r_fill == $past(r_fill) + ONE ||
                      r_fill == $past(r_fill) - ONE || r_fill == '0))
        else $error("command moved fill count by more than one entry");

    a_scan_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !w_last) |=> (r_state == S_SCAN))
        else $error("scan left before visiting every entry");

    a_order_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ORDER && !w_last) |=> (r_state == S_ORDER))
        else $error("ordering pass left early");

    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ORDER && w_last && r_mode == MODE_SORT) |=>
            ($signed(w_word[0]) <= $signed(w_word[1])))
        else $error("first two entries out of order after sort");
`endif

endmodule
